// ===== rtl/radar_beam_pixel_decoder_unit_defines.svh =====
// Assertion macros for the beam pixel decoder.
`ifndef RADAR_BEAM_PIXEL_DECODER_UNIT_DEFINES_SVH
`define RADAR_BEAM_PIXEL_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RBPD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbpd assertion failed");
// next-cycle implication
`define RBPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbpd assertion failed");
`else
`define RBPD_ASSERT_IMPL(name, clk, rst, ante, cons)
`define RBPD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rbpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbpd_pkg;

   localparam int BYTE_W   = 8;
   localparam int ORIGIN_W = 10;
   localparam int PIX_X_W  = 12;
   localparam int PIX_Y_W  = 11;
   localparam int COLOR_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 2'd1;

   localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET = 10'd300;
   localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET = 10'd320;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int SLOTS      = 4;

   typedef struct packed {
      logic                        is_pixel;
      logic signed [PIX_X_W-1:0]   pixel_x;
      logic signed [PIX_Y_W-1:0]   pixel_y;
      logic        [COLOR_W-1:0]   color_index;
      logic                        beam_end;
   } rbpd_result_type;

   // Where the 5-bit codes start inside a byte, by byte index mod 5.
   typedef struct packed {
      logic [2:0] first;
      logic       second;
   } rbpd_start_type;

   function automatic rbpd_start_type code_start(input logic [2:0] phase);
      rbpd_start_type st;
      case (phase)
         3'd0:    st = '{first: 3'd0, second: 1'b1};
         3'd1:    st = '{first: 3'd2, second: 1'b1};
         3'd2:    st = '{first: 3'd4, second: 1'b0};
         3'd3:    st = '{first: 3'd1, second: 1'b1};
         3'd4:    st = '{first: 3'd3, second: 1'b0};
         default: st = '{first: 3'd0, second: 1'b0};
      endcase
      return st;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rbpd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rbpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [rbpd_pkg::BYTE_W-1:0]  data_byte;
   logic                         last_of_record;
   modport source (output valid, data_byte, last_of_record, input ready);
   modport sink   (input valid, data_byte, last_of_record, output ready);
endinterface

interface rbpd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                is_pixel;
   logic signed [rbpd_pkg::PIX_X_W-1:0] pixel_x;
   logic signed [rbpd_pkg::PIX_Y_W-1:0] pixel_y;
   logic        [rbpd_pkg::COLOR_W-1:0] color_index;
   logic                                beam_end;
   modport source (output valid, is_pixel, pixel_x, pixel_y, color_index, beam_end,
                   input ready);
   modport sink   (input valid, is_pixel, pixel_x, pixel_y, color_index, beam_end,
                   output ready);
endinterface

interface rbpd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rbpd_pkg::CSR_IDX_W-1:0]    index;
   logic [rbpd_pkg::ORIGIN_W-1:0]     write_data;
   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/radar_beam_pixel_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "radar_beam_pixel_decoder_unit_defines.svh"
// Channel    Dir   Payload                                            Accept
// req_chan   in    data_byte[7:0], last_of_record                     valid & ready
// rsp_chan   out   is_pixel, pixel_x[11:0], pixel_y[10:0], color[2:0],
//                  beam_end                                           valid & ready
// csr_chan   in    index[1:0], write_data[9:0]                        valid (ready tied high)
//
// A byte is decoded in the cycle it is accepted; its 0 to 4 results enter an
// 8-entry result queue, and into an empty queue the first is visible in the next cycle.
// One result leaves per cycle while rsp_chan.ready is high.
// req_chan.ready drops while fewer than 4 queue entries are free.
// Synchronous reset empties the queue, clears the record position and loads the
// origins with 300 and 320.
module radar_beam_pixel_decoder_unit #(
   parameter int RECORD_BYTES = 200
) (
   input  logic             clock,
   input  logic             reset,
   rbpd_req_if.sink         req_chan,
   rbpd_rsp_if.source       rsp_chan,
   rbpd_csr_if.sink         csr_chan
);

   localparam logic [rbpd_pkg::BYTE_W-1:0] REC_LAST_POS = 8'(RECORD_BYTES - 1);
   localparam int CNT_W = rbpd_pkg::FIFO_PTR_W + 1;

   logic [rbpd_pkg::ORIGIN_W-1:0] origin_x_ff, origin_y_ff;
   logic [rbpd_pkg::BYTE_W-1:0]   held_ff, held_in;
   logic [rbpd_pkg::BYTE_W-1:0]   pos_ff, pos_in;
   logic [2:0]                    phase_ff, phase_in;
   logic                          right_half_ff, right_half_in;
   logic                          stopped_ff, stopped_in;
   logic [rbpd_pkg::PIX_X_W-1:0]  cursor_x_ff, cursor_x_in;
   logic [rbpd_pkg::PIX_Y_W-1:0]  cursor_y_ff, cursor_y_in;

   rbpd_pkg::rbpd_result_type     fifo_ff [rbpd_pkg::FIFO_DEPTH];
   logic [rbpd_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]              count_ff, count_in;

   logic                          req_fire, rsp_fire;
   logic [rbpd_pkg::BYTE_W-1:0]   d;
   logic                          last;
   logic                          start, in_rec, en_a, en_b, hdr_a, hdr_b;
   logic                          zero_a, zero_b, emit_a, emit_b, stop1, stop2, rh;
   logic [2:0]                    phase_a;
   rbpd_pkg::rbpd_start_type      st_a, st_b;
   logic [15:0]                   win_a, win_b;
   logic [4:0]                    code [rbpd_pkg::SLOTS];
   logic [rbpd_pkg::SLOTS-1:0]    slot_v;
   rbpd_pkg::rbpd_result_type     slot_res [rbpd_pkg::SLOTS];
   logic [rbpd_pkg::FIFO_PTR_W-1:0] slot_off [rbpd_pkg::SLOTS];
   logic [2:0]                    push_cnt;
   logic [rbpd_pkg::PIX_X_W-1:0]  cx;
   logic [rbpd_pkg::PIX_Y_W-1:0]  cy;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign d        = req_chan.data_byte;
   assign last     = req_chan.last_of_record;

   // accept only while the queue can take a full byte's worth of results
   assign req_chan.ready = (count_ff <= CNT_W'(rbpd_pkg::FIFO_DEPTH - rbpd_pkg::SLOTS));
   assign csr_chan.ready = 1'b1;

   always_comb begin
      start  = (pos_ff == '0);
      rh     = start ? d[2] : right_half_ff;
      in_rec = (pos_ff <= REC_LAST_POS);
      // codes starting in the held byte, this byte as lookahead
      en_a   = !start && in_rec;
      hdr_a  = (pos_ff == 8'd1);
      // codes starting in this byte when no byte can follow
      en_b   = in_rec && (last || pos_ff == REC_LAST_POS);
      hdr_b  = start;

      phase_a = (phase_ff == 3'd0) ? 3'd4 : phase_ff - 3'd1;
      st_a    = rbpd_pkg::code_start(phase_a);
      st_b    = rbpd_pkg::code_start(phase_ff);
      win_a   = {d, held_ff};
      win_b   = {8'h00, d};

      zero_a = (held_ff == '0) && (d == '0);
      zero_b = (d == '0);
      emit_a = en_a && !hdr_a && !(stopped_ff && !start) && !zero_a;
      stop1  = (stopped_ff && !start) || (en_a && !hdr_a && zero_a);
      emit_b = en_b && !hdr_b && !stop1 && !zero_b;
      stop2  = stop1 || (en_b && !hdr_b && zero_b);

      slot_v[0] = emit_a;
      slot_v[1] = emit_a && st_a.second;
      slot_v[2] = emit_b;
      slot_v[3] = emit_b && st_b.second;
      code[0]   = 5'(win_a >> st_a.first);
      code[1]   = 5'(win_a >> (st_a.first + 3'd5));
      code[2]   = 5'(win_b >> st_b.first);
      code[3]   = 5'(win_b >> (st_b.first + 3'd5));

      cx = start ? {2'b00, origin_x_ff} : cursor_x_ff;
      cy = start ? {1'b0, origin_y_ff}  : cursor_y_ff;
      for (int i = 0; i < rbpd_pkg::SLOTS; i++) begin
         if (slot_v[i]) begin
            if (code[i][0]) begin
               cx = rh ? cx + 12'd1 : cx - 12'd1;
            end
            if (code[i][1]) begin
               cy = cy - 11'd1;
            end
         end
         slot_res[i] = '{is_pixel: 1'b1, pixel_x: $signed(cx), pixel_y: $signed(cy),
                         color_index: code[i][4:2], beam_end: 1'b0};
      end

      // mark the record end on the last result, or give a bare one
      if (last) begin
         if (slot_v == '0) begin
            slot_v[0]   = 1'b1;
            slot_res[0] = '{is_pixel: 1'b0, pixel_x: '0, pixel_y: '0,
                            color_index: '0, beam_end: 1'b1};
         end else if (slot_v[3]) begin
            slot_res[3].beam_end = 1'b1;
         end else if (slot_v[2]) begin
            slot_res[2].beam_end = 1'b1;
         end else if (slot_v[1]) begin
            slot_res[1].beam_end = 1'b1;
         end else begin
            slot_res[0].beam_end = 1'b1;
         end
      end

      push_cnt = '0;
      for (int i = 0; i < rbpd_pkg::SLOTS; i++) begin
         slot_off[i] = rbpd_pkg::FIFO_PTR_W'(push_cnt);
         push_cnt    = push_cnt + 3'(slot_v[i]);
      end

      cursor_x_in   = cx;
      cursor_y_in   = cy;
      right_half_in = rh;
      held_in       = last ? '0 : d;
      stopped_in    = last ? 1'b0 : stop2;
      if (last) begin
         pos_in   = '0;
         phase_in = '0;
      end else if (pos_ff == 8'hFF) begin
         pos_in   = pos_ff;
         phase_in = phase_ff;
      end else begin
         pos_in   = pos_ff + 8'd1;
         phase_in = (phase_ff == 3'd4) ? 3'd0 : phase_ff + 3'd1;
      end

      count_in = count_ff + (req_fire ? CNT_W'(push_cnt) : '0) - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= rbpd_pkg::ORIGIN_X_RESET;
         origin_y_ff   <= rbpd_pkg::ORIGIN_Y_RESET;
         held_ff       <= '0;
         pos_ff        <= '0;
         phase_ff      <= '0;
         right_half_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         cursor_x_ff   <= {2'b00, rbpd_pkg::ORIGIN_X_RESET};
         cursor_y_ff   <= {1'b0, rbpd_pkg::ORIGIN_Y_RESET};
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               rbpd_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_chan.write_data;
               rbpd_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_chan.write_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            held_ff       <= held_in;
            pos_ff        <= pos_in;
            phase_ff      <= phase_in;
            right_half_ff <= right_half_in;
            stopped_ff    <= stopped_in;
            cursor_x_ff   <= cursor_x_in;
            cursor_y_ff   <= cursor_y_in;
            wr_ptr_ff     <= wr_ptr_ff + rbpd_pkg::FIFO_PTR_W'(push_cnt);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + rbpd_pkg::FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < rbpd_pkg::SLOTS; i++) begin
         if (req_fire && slot_v[i]) begin
            fifo_ff[wr_ptr_ff + slot_off[i]] <= slot_res[i];
         end
      end
   end

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.is_pixel    = fifo_ff[rd_ptr_ff].is_pixel;
   assign rsp_chan.pixel_x     = fifo_ff[rd_ptr_ff].pixel_x;
   assign rsp_chan.pixel_y     = fifo_ff[rd_ptr_ff].pixel_y;
   assign rsp_chan.color_index = fifo_ff[rd_ptr_ff].color_index;
   assign rsp_chan.beam_end    = fifo_ff[rd_ptr_ff].beam_end;

   `RBPD_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(rbpd_pkg::FIFO_DEPTH))
   `RBPD_ASSERT_NEXT(a_record_wrap, clock, reset, req_fire && last, pos_ff == '0 && !stopped_ff)
   `RBPD_ASSERT_IMPL(a_last_gives_result, clock, reset, req_fire && last, push_cnt != '0)

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import rbpd_pkg::*;

   localparam int REC_BYTES     = 200;
   localparam int HEADER_BITS   = 10;
   localparam int CODE_BITS     = 5;
   localparam int STEP_X_BIT    = 0;
   localparam int STEP_Y_BIT    = 1;
   localparam int COLOR_LSB     = 2;
   localparam int HALF_BIT      = 2;
   localparam int POS_MAX       = 255;
   localparam int ORIGIN_MAX    = 1023;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 50;
   localparam int MAX_PRINTS    = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic clock;
   logic reset;

   rbpd_req_if req_if();
   rbpd_rsp_if rsp_if();
   rbpd_csr_if csr_if();

   radar_beam_pixel_decoder_unit #(.RECORD_BYTES(REC_BYTES)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // decoder state as the block should hold it
   logic [ORIGIN_W-1:0] org_x, org_y;
   logic [BYTE_W-1:0]   held_byte;
   int unsigned         beam_pos;
   bit                  right_half;
   logic [PIX_X_W-1:0]  cur_x;
   logic [PIX_Y_W-1:0]  cur_y;
   bit                  beam_stopped;

   rbpd_result_type   pending_pixels[$];
   rbpd_result_type   byte_pixels[$];
   rbpd_result_type   want_px;
   logic [BYTE_W-1:0] beam_bytes[$];

   int  error_count = 0;
   int  items_sent  = 0;
   int  quiet_cycles = 0;
   int  rsp_hold    = 0;
   bit  steady      = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [ORIGIN_W-1:0] pick_origin();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return ORIGIN_W'(ORIGIN_MAX);
         default: return ORIGIN_W'($urandom_range(0, ORIGIN_MAX));
      endcase
   endfunction

   function automatic void clear_beam_state();
      org_x        = ORIGIN_X_RESET;
      org_y        = ORIGIN_Y_RESET;
      held_byte    = '0;
      beam_pos     = 0;
      right_half   = 0;
      cur_x        = PIX_X_W'(ORIGIN_X_RESET);
      cur_y        = PIX_Y_W'(ORIGIN_Y_RESET);
      beam_stopped = 0;
   endfunction

   // Walk the codes that start in byte s; hi is the lookahead byte.
   function automatic void decode_codes(input int unsigned s, input logic [BYTE_W-1:0] lo,
                                        input logic [BYTE_W-1:0] hi);
      int unsigned     b;
      logic [15:0]     pair;
      logic [4:0]      code;
      rbpd_result_type px;
      pair = {hi, lo};
      for (int k = 0; k < BYTE_W; k++) begin
         b = 8 * s + k;
         if (b < HEADER_BITS || (b % CODE_BITS) != 0)
            continue;
         if (beam_stopped)
            return;
         if (lo == '0 && hi == '0) begin
            beam_stopped = 1;
            return;
         end
         code = 5'(pair >> k);
         if (code[STEP_X_BIT])
            cur_x = right_half ? cur_x + 12'd1 : cur_x - 12'd1;
         if (code[STEP_Y_BIT])
            cur_y = cur_y - 11'd1;
         px.is_pixel    = 1'b1;
         px.pixel_x     = cur_x;
         px.pixel_y     = cur_y;
         px.color_index = code[COLOR_LSB +: COLOR_W];
         px.beam_end    = 1'b0;
         byte_pixels.push_back(px);
      end
   endfunction

   function automatic void decode_beam_byte(input logic [BYTE_W-1:0] d, input bit last);
      int unsigned     pos;
      rbpd_result_type px;
      pos = beam_pos;
      byte_pixels.delete();
      if (pos == 0) begin
         cur_x        = PIX_X_W'(org_x);
         cur_y        = PIX_Y_W'(org_y);
         right_half   = d[HALF_BIT];
         beam_stopped = 0;
      end
      if (pos >= 1 && pos - 1 < REC_BYTES - 1)
         decode_codes(pos - 1, held_byte, d);
      // no further byte can follow: lookahead reads as zero
      if (pos < REC_BYTES && (last || pos == REC_BYTES - 1))
         decode_codes(pos, d, '0);
      held_byte = d;
      if (beam_pos < POS_MAX)
         beam_pos++;
      if (last) begin
         if (byte_pixels.size() > 0) begin
            byte_pixels[byte_pixels.size() - 1].beam_end = 1'b1;
         end else begin
            px = '0;
            px.beam_end = 1'b1;
            byte_pixels.push_back(px);
         end
         beam_pos     = 0;
         beam_stopped = 0;
         held_byte    = '0;
      end
      foreach (byte_pixels[i])
         pending_pixels.push_back(byte_pixels[i]);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] d, input bit last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.data_byte      <= d;
      req_if.last_of_record <= last;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      decode_beam_byte(d, last);
      items_sent++;
   endtask

   // Hold the sender until every pending result has left the block.
   task automatic drain_results(input bit settle);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_origin(input logic [CSR_IDX_W-1:0] idx,
                               input logic [ORIGIN_W-1:0] value);
      @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.index      <= idx;
      csr_if.write_data <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      if (idx == CSR_ORIGIN_X)
         org_x = value;
      else if (idx == CSR_ORIGIN_Y)
         org_y = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_origins(input logic [ORIGIN_W-1:0] x, input logic [ORIGIN_W-1:0] y);
      drain_results(1);
      write_origin(CSR_ORIGIN_X, x);
      write_origin(CSR_ORIGIN_Y, y);
   endtask

   task automatic fill_beam(input int len, input int zero_pct);
      beam_bytes.delete();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < zero_pct)
            beam_bytes.push_back('0);
         else
            beam_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_beam(input bit pause_midway);
      foreach (beam_bytes[i]) begin
         if (pause_midway && i == beam_bytes.size() / 2)
            drain_results(0);
         send_byte(beam_bytes[i], i == beam_bytes.size() - 1);
      end
   endtask

   task automatic test_directed_beams();
      // one-byte beam: nothing decodes, bare beam end
      beam_bytes = '{8'hFF};
      send_beam(0);
      // right half, final byte decoded against a zero lookahead
      beam_bytes = '{8'h04, 8'hFF, 8'hFF, 8'h00};
      send_beam(0);
      // left half, mixed colors
      beam_bytes = '{8'h00, 8'hA5, 8'h3C, 8'hE7, 8'h5A, 8'hFF};
      send_beam(0);
      // two zero bytes stop the beam; later bytes give nothing
      beam_bytes = '{8'h04, 8'h55, 8'h00, 8'h00, 8'hFF, 8'h81};
      send_beam(0);
   endtask

   task automatic test_origin_extremes();
      // left half from zero drives both coordinates negative
      set_origins('0, '0);
      write_origin(CSR_SPARE_A, ORIGIN_W'($urandom_range(0, ORIGIN_MAX)));
      write_origin(CSR_SPARE_B, ORIGIN_W'($urandom_range(0, ORIGIN_MAX)));
      beam_bytes = '{8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_beam(0);
      set_origins(ORIGIN_W'(ORIGIN_MAX), ORIGIN_W'(ORIGIN_MAX));
      beam_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_beam(0);
   endtask

   task automatic test_long_beams();
      set_origins(pick_origin(), pick_origin());
      // run past the record size and into position saturation
      fill_beam($urandom_range(POS_MAX + 1, POS_MAX + 4), 0);
      send_beam(0);
   endtask

   task automatic test_random_beams();
      int start;
      int beams;
      int r;
      start = items_sent;
      beams = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (beams % 4 == 3) begin
            steady = 0;
            set_origins(pick_origin(), pick_origin());
            if ($urandom_range(0, 3) == 0)
               write_origin($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                            ORIGIN_W'($urandom_range(0, ORIGIN_MAX)));
         end
         steady = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 70)
            fill_beam($urandom_range(0, 9) < 4 ? $urandom_range(1, 3) : $urandom_range(4, 24),
                      10);
         else if (r < 85)
            fill_beam($urandom_range(1, 16), 50);
         else
            fill_beam($urandom_range(25, 60), 5);
         send_beam(beams == 3 || $urandom_range(0, 19) == 0);
         beams++;
      end
      steady = 0;
   endtask

   // response side: random stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result with none pending", 0, 0);
         end else begin
            want_px = pending_pixels.pop_front();
            if (rsp_if.is_pixel !== want_px.is_pixel)
               report_mismatch("is_pixel", rsp_if.is_pixel, want_px.is_pixel);
            if (rsp_if.pixel_x !== want_px.pixel_x)
               report_mismatch("pixel_x", rsp_if.pixel_x, want_px.pixel_x);
            if (rsp_if.pixel_y !== want_px.pixel_y)
               report_mismatch("pixel_y", rsp_if.pixel_y, want_px.pixel_y);
            if (rsp_if.color_index !== want_px.color_index)
               report_mismatch("color_index", rsp_if.color_index, want_px.color_index);
            if (rsp_if.beam_end !== want_px.beam_end)
               report_mismatch("beam_end", rsp_if.beam_end, want_px.beam_end);
         end
      end
   end

   // end the run if no handshake completes for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.data_byte      = '0;
      req_if.last_of_record = 1'b0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.index          = '0;
      csr_if.write_data     = '0;
      clear_beam_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_beams();
      test_origin_extremes();
      test_long_beams();
      test_random_beams();

      drain_results(1);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
